// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property holds on every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/bls_pkg.sv =====
// Types and constants for the breakpoint LFO.
// No dependencies.
package bls_pkg;
  typedef enum logic [1:0] {
    CfgPhaseStep = 2'd0,
    CfgEnvMode   = 2'd1,
    CfgPointCnt  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StSearch,
    StTDiv,
    StNum,
    StDen,
    StSDiv,
    StMul,
    StOut
  } state_e;

  localparam int SFrac        = 20;
  localparam int TensionLimit = 32765;
  localparam int DivBits      = 56;
endpackage

// ===== design/breakpoint_lfo_sigmoid.sv =====
// Breakpoint LFO with sigmoid-shaped segments, top level.
// Depends on bls_pkg.
//
//  channel | direction | signals
//  in      | request   | in_valid_i/in_ready_o, action_i .. point_tension_i
//  out     | result    | out_valid_o/out_ready_i, curve_value_o, phase_now_o
//  cfg     | write     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// A write request is stored when it is taken. A tick searches the segments;
// on a hit with more than two points it runs StTDiv, StNum, StDen, StSDiv,
// StMul and StOut; its two 56-step shift-subtract divisions share one divider.
// rst_ni resets phase and gate and loads the default breakpoints at once.
// The result waits in an output register; no request is taken while it waits.
module breakpoint_lfo_sigmoid #(
  parameter int MAX_POINTS = 16,
  parameter int PHASE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic                  gate_i,
  input  logic signed [23:0]    phase_offset_i,
  input  logic [3:0]            point_index_i,
  input  logic [16:0]           point_x_i,
  input  logic signed [15:0]    point_y_i,
  input  logic signed [15:0]    point_tension_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    curve_value_o,
  output logic [24:0]           phase_now_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i
);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = IW + 1;
  localparam int PW = PHASE_BITS + 1;
  localparam int SW = PW + 26;
  localparam int DW = bls_pkg::DivBits;

  bls_pkg::state_e state_q, state_d;

  logic [23:0] step_q;
  logic        env_q;
  logic [4:0]  pcnt_q;
  logic [PW-1:0] phase_q;
  logic        gate_q;
  logic [16:0] bx_q [MAX_POINTS];
  logic signed [15:0] by_q [MAX_POINTS];
  logic signed [15:0] bt_q [MAX_POINTS];

  logic [IW-1:0] idx_q;
  logic [CW-1:0] n_q;
  logic signed [15:0] y1_q, res_q;
  logic signed [16:0] dy_q;
  logic signed [16:0] k_q;
  logic [DW-1:0] dnum_q, dden_q, quo_q, rem_q;
  logic [5:0]  cnt_q;
  logic signed [63:0] acc_q;
  logic [PW-1:0] pnow_q;
  logic        gate_in_q;
  logic signed [23:0] offs_q;
  logic        ovalid_q;
  logic        hit_done_q;

  // effective point count
  logic [CW-1:0] n_eff;
  always_comb begin
    if (pcnt_q < 5'd2) n_eff = CW'(2);
    else if (32'(pcnt_q) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
    else n_eff = CW'(pcnt_q);
  end

  // phase in Q0.32, widened
  logic [40:0] xph;
  assign xph = 41'(phase_q) << (32 - PHASE_BITS);

  logic [IW-1:0] idx_n;
  assign idx_n = idx_q + IW'(1);
  logic [40:0] x1w, x2w;
  assign x1w = 41'(bx_q[idx_q]) << 16;
  assign x2w = 41'(bx_q[idx_n]) << 16;
  logic hit;
  assign hit = (xph >= x1w) && (xph < x2w);
  logic last_seg;
  assign last_seg = (CW'(idx_q) + CW'(2)) >= n_q;

  // shared restoring divider step
  logic [DW:0] rtry;
  assign rtry = {rem_q, dnum_q[DW-1]} - {1'b0, dden_q};

  logic signed [21:0] t_s;
  assign t_s = {1'b0, quo_q[20:0]};
  logic signed [17:0] km_s;
  assign km_s = 18'sd32768 - 18'(k_q);
  logic signed [22:0] tdiff;
  assign tdiff = 23'sd1048576 - 23'({quo_q[20:0], 1'b0});

  assign in_ready_o  = (state_q == bls_pkg::StIdle) && !ovalid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign curve_value_o = res_q;
  assign phase_now_o = 25'(pnow_q);

  logic tick_acc, wr_acc;
  assign tick_acc = in_valid_i && in_ready_o && !action_i;
  assign wr_acc   = in_valid_i && in_ready_o && action_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bls_pkg::StIdle:   if (tick_acc) state_d = bls_pkg::StSearch;
      bls_pkg::StSearch: begin
        if (hit) begin
          state_d = (n_q == CW'(2)) ? bls_pkg::StOut : bls_pkg::StTDiv;
        end else if (last_seg) begin
          state_d = bls_pkg::StOut;
        end
      end
      bls_pkg::StTDiv:   if (cnt_q == 6'(DW - 1)) state_d = bls_pkg::StNum;
      bls_pkg::StNum:    state_d = bls_pkg::StDen;
      bls_pkg::StDen:    state_d = bls_pkg::StSDiv;
      bls_pkg::StSDiv:   if (cnt_q == 6'(DW - 1)) state_d = bls_pkg::StMul;
      bls_pkg::StMul:    state_d = bls_pkg::StOut;
      bls_pkg::StOut:    state_d = bls_pkg::StIdle;
      default:           state_d = bls_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bls_pkg::StIdle;
    else state_q <= state_d;
  end

  // config and breakpoint storage
  logic signed [15:0] ten_sat;
  always_comb begin
    if (point_tension_i > 16'sd32765) ten_sat = 16'sd32765;
    else if (point_tension_i < -16'sd32765) ten_sat = -16'sd32765;
    else ten_sat = point_tension_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      env_q  <= 1'b0;
      pcnt_q <= 5'd3;
      for (int i = 0; i < MAX_POINTS; i++) begin
        bx_q[i] <= '0;
        by_q[i] <= '0;
        bt_q[i] <= '0;
      end
      bx_q[1] <= 17'd32768;
      if (MAX_POINTS > 2) bx_q[2] <= 17'd65536;
      by_q[1] <= 16'sd16384;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bls_pkg::CfgPhaseStep: step_q <= cfg_data_i;
          bls_pkg::CfgEnvMode:   env_q  <= cfg_data_i[0];
          bls_pkg::CfgPointCnt:  pcnt_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (wr_acc && (32'(point_index_i) < MAX_POINTS)) begin
        bx_q[IW'(point_index_i)] <= point_x_i;
        by_q[IW'(point_index_i)] <= point_y_i;
        bt_q[IW'(point_index_i)] <= ten_sat;
      end
    end
  end

  // phase update
  logic signed [SW-1:0] p_sum;
  logic signed [SW-1:0] cyc;
  logic [PW-1:0] p_new;
  assign cyc = SW'(1) <<< PHASE_BITS;
  assign p_sum = ((gate_in_q && !gate_q) ? '0 : SW'(signed'({1'b0, phase_q})))
               + SW'(offs_q) + SW'(signed'({1'b0, step_q}));
  always_comb begin
    if (env_q) begin
      if (p_sum < 0) p_new = '0;
      else if (p_sum > cyc) p_new = PW'(cyc);
      else p_new = PW'(p_sum);
    end else begin
      p_new = {1'b0, p_sum[PHASE_BITS-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      gate_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (state_q == bls_pkg::StOut) begin
        ovalid_q <= 1'b1;
        phase_q  <= p_new;
        gate_q   <= gate_in_q;
      end else if (out_valid_o && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      bls_pkg::StIdle: begin
        if (tick_acc) begin
          idx_q     <= '0;
          n_q       <= n_eff;
          pnow_q    <= phase_q;
          gate_in_q <= gate_i;
          offs_q    <= phase_offset_i;
        end
      end
      bls_pkg::StSearch: begin
        if (hit) begin
          y1_q   <= by_q[idx_q];
          res_q  <= by_q[idx_q];
          dy_q   <= 17'(by_q[idx_n]) - 17'(by_q[idx_q]);
          k_q    <= (by_q[idx_n] < by_q[idx_q]) ? -17'(bt_q[idx_q]) : 17'(bt_q[idx_q]);
          dnum_q <= DW'(xph - x1w) << 20;
          dden_q <= DW'(x2w - x1w);
          rem_q  <= '0;
          quo_q  <= '0;
          cnt_q  <= '0;
        end else if (last_seg) begin
          res_q <= by_q[n_q[IW-1:0] - IW'(1)];
        end else begin
          idx_q <= idx_n;
        end
      end
      bls_pkg::StTDiv, bls_pkg::StSDiv: begin
        if (!rtry[DW]) begin
          rem_q <= rtry[DW-1:0];
          quo_q <= {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[DW-2:0], dnum_q[DW-1]};
          quo_q <= {quo_q[DW-2:0], 1'b0};
        end
        dnum_q <= {dnum_q[DW-2:0], 1'b0};
        cnt_q  <= cnt_q + 6'd1;
      end
      bls_pkg::StNum: begin
        // num = t*(32768-k); stored shifted by 2^20
        acc_q <= 64'(t_s * km_s);
      end
      bls_pkg::StDen: begin
        dnum_q <= DW'(acc_q <<< 20);
        dden_q <= DW'((64'sd1 <<< 35) + 64'(k_q * tdiff));
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      bls_pkg::StMul: begin
        acc_q <= 64'(signed'({1'b0, quo_q[21:0]}) * 23'(dy_q)) + (64'sd1 <<< 19);
      end
      bls_pkg::StOut: begin
        if (n_q != CW'(2) && state_d == bls_pkg::StIdle && hit_done_q)
          res_q <= 16'(64'(y1_q) + (acc_q >>> 20));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hit_done_q <= 1'b0;
    else if (state_q == bls_pkg::StIdle) hit_done_q <= 1'b0;
    else if (state_q == bls_pkg::StMul) hit_done_q <= 1'b1;
  end
endmodule

// ===== design/bls_checker.sv =====
// Port-level checker for breakpoint_lfo_sigmoid, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module bls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [24:0] phase_now_o
);
  `ASSERT_ALWAYS(a_no_take_while_held, clk_i, rst_ni, !(out_valid_o && in_ready_o))
  `ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, in_valid_i && in_ready_o && !action_i, !in_ready_o)
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(phase_now_o))
  `ASSERT_ALWAYS(a_phase_range, clk_i, rst_ni, !out_valid_o || phase_now_o <= 25'h1000000)
endmodule

bind breakpoint_lfo_sigmoid bls_checker u_bls_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .action_i(action_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .phase_now_o(phase_now_o)
);

// ===== sim/breakpoint_lfo_sigmoid_test.sv =====
// Self-checking testbench for breakpoint_lfo_sigmoid: random and directed ticks,
// breakpoint writes and register writes, checked against a cycle-free predictor.
// Depends on bls_pkg and the breakpoint_lfo_sigmoid RTL.
module breakpoint_lfo_sigmoid_test;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam logic       ActTick   = 1'b0;
  localparam logic       ActWrite  = 1'b1;
  localparam longint     Cycle     = 64'd1 << 24;

  class curve_lfo_predictor;
    longint    step;
    bit        env_mode;
    int        count;
    longint    phase;
    bit        gate_q;
    longint    bx[16];
    longint    by[16];
    longint    bt[16];
    logic signed [15:0] expected_curve[$];
    logic [24:0]        expected_phase[$];
    int        errors;

    function new();
      step = 0; env_mode = 0; count = 3; phase = 0; gate_q = 0; errors = 0;
      foreach (bx[i]) begin
        bx[i] = 0; by[i] = 0; bt[i] = 0;
      end
      bx[1] = 32768; bx[2] = 65536; by[1] = 16384;
    endfunction

    function void configure(logic [1:0] idx, logic [23:0] data);
      case (idx)
        bls_pkg::CfgPhaseStep: step = data;
        bls_pkg::CfgEnvMode:   env_mode = data[0];
        bls_pkg::CfgPointCnt:  count = data[4:0];
        default: ;
      endcase
    endfunction

    function longint shaped_value(longint ph);
      int n;
      longint x, x1, x2, y1, dy, k, t, num, den, s;
      n = count < 2 ? 2 : (count > 16 ? 16 : count);
      x = ph << 8;
      for (int i = 0; i + 1 < n; i++) begin
        x1 = bx[i] << 16;
        x2 = bx[i + 1] << 16;
        if (x >= x1 && x < x2) begin
          y1 = by[i];
          if (n == 2) return y1;
          dy = by[i + 1] - y1;
          k = dy < 0 ? -bt[i] : bt[i];
          t = ((x - x1) << bls_pkg::SFrac) / (x2 - x1);
          num = t * (32768 - k);
          den = (64'sd1 <<< 35) + k * ((64'sd1 <<< bls_pkg::SFrac) - 2 * t);
          s = (num <<< bls_pkg::SFrac) / den;
          return y1 + ((s * dy + (64'sd1 <<< (bls_pkg::SFrac - 1))) >>> bls_pkg::SFrac);
        end
      end
      return by[n - 1];
    endfunction

    function void note_request(logic act, logic gate, logic signed [23:0] offset,
                               logic [3:0] idx, logic [16:0] px,
                               logic signed [15:0] py, logic signed [15:0] pt);
      longint p, ten;
      if (act == ActWrite) begin
        ten = pt;
        if (ten > bls_pkg::TensionLimit) ten = bls_pkg::TensionLimit;
        if (ten < -bls_pkg::TensionLimit) ten = -bls_pkg::TensionLimit;
        bx[idx] = px; by[idx] = py; bt[idx] = ten;
        return;
      end
      expected_curve = {expected_curve, 16'(shaped_value(phase))};
      expected_phase = {expected_phase, 25'(phase)};
      if (gate && !gate_q) phase = 0;
      gate_q = gate;
      p = phase + longint'(offset) + step;
      if (env_mode) begin
        if (p < 0) p = 0;
        if (p > Cycle) p = Cycle;
      end else begin
        p = p % Cycle;
        if (p < 0) p += Cycle;
      end
      phase = p;
    endfunction

    function void check_result(logic signed [15:0] curve, logic [24:0] ph);
      logic signed [15:0] ec;
      logic [24:0] ep;
      if (expected_curve.size() == 0) begin
        $display("%0t: unexpected result curve %0d phase %0d", $time, curve, ph);
        errors++;
        return;
      end
      ec = expected_curve.pop_front();
      ep = expected_phase.pop_front();
      if (curve !== ec) begin
        $display("%0t: curve_value expected %0d actual %0d", $time, ec, curve);
        errors++;
      end
      if (ph !== ep) begin
        $display("%0t: phase_now expected %0d actual %0d", $time, ep, ph);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, action_i, gate_i;
  logic signed [23:0] phase_offset_i;
  logic [3:0] point_index_i;
  logic [16:0] point_x_i;
  logic signed [15:0] point_y_i, point_tension_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] curve_value_o;
  logic [24:0] phase_now_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  curve_lfo_predictor lfo;
  bit quiet;
  bit gate_lvl;

  breakpoint_lfo_sigmoid dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("breakpoint_lfo_sigmoid_test NOT OK");
    $finish;
  end

  task automatic send_request(logic act, logic gate, logic signed [23:0] offset,
                              logic [3:0] idx, logic [16:0] px,
                              logic signed [15:0] py, logic signed [15:0] pt);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = act; gate_i = gate; phase_offset_i = offset;
    point_index_i = idx; point_x_i = px; point_y_i = py; point_tension_i = pt;
    do @(posedge clk_i); while (!in_ready_o);
    lfo.note_request(act, gate, offset, idx, px, py, pt);
  endtask

  task automatic tick(logic gate, logic signed [23:0] offset);
    send_request(ActTick, gate, offset, 4'($urandom), 17'($urandom), 16'($urandom),
                 16'($urandom));
  endtask

  task automatic put_point(logic [3:0] idx, logic [16:0] px, logic signed [15:0] py,
                           logic signed [15:0] pt);
    send_request(ActWrite, 1'($urandom), 24'($urandom), idx, px, py, pt);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (lfo.expected_curve.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    lfo.configure(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_curve(int n);
    int base;
    for (int i = 0; i < n; i++) begin
      base = i * 65536 / (n - 1);
      if (i != 0 && i != n - 1) base += $urandom_range(2000) - 1000;
      put_point(4'(i), 17'(base), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_tick();
    logic signed [23:0] offs;
    if ($urandom_range(99) < 5) gate_lvl = ~gate_lvl;
    case ($urandom_range(9))
      0: offs = 24'($urandom);
      1, 2: offs = 24'($urandom_range(8191)) - 24'sd4096;
      default: offs = '0;
    endcase
    tick(gate_lvl, offs);
  endtask

  always begin
    @(negedge clk_i);
    out_ready_i = quiet ? 1'b1 : ($urandom_range(99) >= 15);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) lfo.check_result(curve_value_o, phase_now_o);
  end

  initial begin
    int cnt;
    lfo = new();
    quiet = 0; gate_lvl = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0; cfg_valid_i = 1'b0;
    action_i = ActTick; gate_i = 1'b0; phase_offset_i = '0; point_index_i = '0;
    point_x_i = '0; point_y_i = '0; point_tension_i = '0;
    cfg_index_i = bls_pkg::CfgPhaseStep; cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset curve, offsets at both extremes, gate edge
    tick(1'b0, 24'sd4194304);
    tick(1'b0, 24'sd8388607);
    tick(1'b0, -24'sd8388608);
    tick(1'b1, 24'sd1000);
    tick(1'b1, 24'sd0);
    put_point(4'd15, 17'd65536, 16'sh7fff, 16'sh7fff);
    put_point(4'd1, 17'd32768, -16'sd32768, -16'sd32768);
    put_point(4'd0, 17'd0, 16'sh7fff, 16'sd32767);
    tick(1'b0, 24'sd0);
    tick(1'b0, 24'sd2097152);
    put_point(4'd1, 17'd0, 16'sd5, 16'sd100);
    tick(1'b0, 24'sd0);
    settle();
    write_reg(bls_pkg::CfgEnvMode, 24'd1);
    write_reg(bls_pkg::CfgPhaseStep, 24'd8388608);
    write_reg(bls_pkg::CfgPointCnt, 24'd2);
    write_reg(CfgUnused, 24'hffffff);
    tick(1'b0, 24'sd0);
    tick(1'b0, 24'sd8388607);
    tick(1'b0, 24'sd8388607);
    tick(1'b0, -24'sd8388608);
    tick(1'b0, -24'sd8388608);
    settle();
    write_reg(bls_pkg::CfgPointCnt, 24'd31);
    tick(1'b0, 24'sd0);
    settle();
    write_reg(bls_pkg::CfgPointCnt, 24'd0);
    tick(1'b0, 24'sd0);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: write_reg(bls_pkg::CfgPhaseStep, 24'($urandom_range(300000)));
        1: write_reg(bls_pkg::CfgPhaseStep, 24'd8388608);
        2: write_reg(bls_pkg::CfgPhaseStep, 24'd0);
        default: write_reg(bls_pkg::CfgPhaseStep, 24'($urandom_range(8388608)));
      endcase
      write_reg(bls_pkg::CfgEnvMode, 24'(ph % 2));
      cnt = (ph == 0) ? 2 : (ph == 1) ? 16 : (ph == 2) ? 3 : $urandom_range(2, 16);
      write_reg(bls_pkg::CfgPointCnt, 24'(cnt));
      quiet = (ph == 5);
      load_curve(cnt);
      for (int i = 0; i < 190; i++) begin
        if ($urandom_range(99) < 4)
          put_point(4'($urandom), 17'($urandom_range(65536)), 16'($urandom), 16'($urandom));
        else
          random_tick();
      end
      quiet = 0;
    end

    settle();
    if (lfo.errors == 0) begin
      $display("breakpoint_lfo_sigmoid_test OK");
    end else begin
      $display("breakpoint_lfo_sigmoid_test NOT OK");
    end
    $finish;
  end
endmodule
